// ----- design/block_frame_crc_verifier_core_assert.svh -----
// Assertion macros for the frame CRC verifier core.
// Included by the top level; no other dependencies.
`ifndef BLOCK_FRAME_CRC_VERIFIER_CORE_ASSERT_SVH
`define BLOCK_FRAME_CRC_VERIFIER_CORE_ASSERT_SVH

// Clocked property, disabled while reset is asserted
`define BFCV_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define BFCV_ASSERT_NEVER(name, clk, rst_n, expr, msg) \
  `BFCV_ASSERT(name, clk, rst_n, !(expr), msg)

`endif

// ----- design/bfcv_pkg.sv -----
// Package for the frame CRC verifier: phase and status codes, CRC-32C byte step.
// No dependencies.
package bfcv_pkg;

  // Frame parsing phase, one-hot
  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_PAY  = 4'b0010,
    PH_CRC  = 4'b0100,
    PH_DROP = 4'b1000
  } phase_e;

  // Per-frame status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SIZE     = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_e;

  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [32:0] FrameOverhead = 33'd8;  // length field plus checksum field

  // Reflected CRC-32C update over one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/block_frame_crc_verifier_core.sv -----
// Length-prefixed frame checker with running CRC-32C, top level.
// Depends on bfcv_pkg and block_frame_crc_verifier_core_assert.svh.
//
// Takes one frame byte per transaction (32-bit little-endian length, payload,
// 32-bit little-endian CRC-32C) and returns at most one result per byte: the
// payload byte passed through and/or the frame status (0 ok, 1 size mismatch,
// 2 truncated, 3 checksum mismatch). Payload bytes are trustworthy only once an
// ok status follows. After an error, bytes are swallowed up to and including the
// next end_of_data byte. The core takes one byte every clock unless the output
// is held off; each byte passes the input register, then the result register,
// and the combinational byte-wise CRC-32C step between them sets the clock rate.
module block_frame_crc_verifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_data_i,
  input  logic        check_size_i,
  input  logic [31:0] expected_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic        status_valid_o,
  output logic [1:0]  status_o
);
  import bfcv_pkg::*;

  // Input stage
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_eod_q;
  logic        s1_chk_q;
  logic [31:0] s1_exp_q;

  // Frame state
  phase_e      phase_q, phase_d;
  logic [31:0] byte_cnt_q, byte_cnt_d;
  logic [31:0] pay_len_q, pay_len_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rx_crc_q, rx_crc_d;
  logic [31:0] exp_latch_q, exp_latch_d;
  logic        chk_latch_q, chk_latch_d;

  // Result register
  logic        res_valid_q;
  logic        res_pay_v_q;
  logic [7:0]  res_byte_q;
  logic        res_st_v_q;
  status_e     res_st_q;

  // Step results
  logic        pay_v;
  logic        st_v;
  status_e     st;
  logic [31:0] len_new;
  logic [31:0] rx_new;
  logic [31:0] cnt_inc;
  logic [32:0] total_len;
  logic [4:0]  shamt;

  logic out_free;
  logic s1_adv;
  logic in_fire;

  assign out_free   = !res_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= data_byte_i;
      s1_eod_q  <= end_of_data_i;
      s1_chk_q  <= check_size_i;
      s1_exp_q  <= expected_size_i;
    end
  end

  // Frame parser and CRC step
  assign cnt_inc = byte_cnt_q + 32'd1;
  assign shamt   = {byte_cnt_q[1:0], 3'b000};

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    pay_len_d   = pay_len_q;
    crc_d       = crc_q;
    rx_crc_d    = rx_crc_q;
    exp_latch_d = exp_latch_q;
    chk_latch_d = chk_latch_q;
    pay_v       = 1'b0;
    st_v        = 1'b0;
    st          = ST_OK;
    len_new     = ((byte_cnt_q[1:0] == 2'd0) ? 32'd0 : pay_len_q)
                  | ({24'd0, s1_byte_q} << shamt);
    rx_new      = rx_crc_q | ({24'd0, s1_byte_q} << shamt);
    total_len   = FrameOverhead + {1'b0, len_new};

    if (s1_adv) begin
      case (phase_q)
        PH_LEN: begin
          // first length byte samples the size check and resets the frame
          if (byte_cnt_q[1:0] == 2'd0) begin
            chk_latch_d = s1_chk_q;
            exp_latch_d = s1_exp_q;
            crc_d       = CrcInit;
            rx_crc_d    = 32'd0;
          end
          pay_len_d  = len_new;
          byte_cnt_d = cnt_inc;
          if (byte_cnt_q[1:0] == 2'd3) begin
            byte_cnt_d = 32'd0;
            if (chk_latch_q && (total_len != {1'b0, exp_latch_q})) begin
              st_v = 1'b1;
              st   = ST_SIZE;
            end else if (s1_eod_q) begin
              st_v = 1'b1;
              st   = ST_TRUNC;
            end else begin
              phase_d = (len_new == 32'd0) ? PH_CRC : PH_PAY;
            end
          end else if (s1_eod_q) begin
            st_v = 1'b1;
            st   = ST_TRUNC;
          end
        end
        PH_PAY: begin
          pay_v      = 1'b1;
          crc_d      = crc32c_byte(crc_q, s1_byte_q);
          byte_cnt_d = cnt_inc;
          if (s1_eod_q) begin
            st_v = 1'b1;
            st   = ST_TRUNC;
          end else if (cnt_inc >= pay_len_q) begin
            byte_cnt_d = 32'd0;
            phase_d    = PH_CRC;
          end
        end
        PH_CRC: begin
          rx_crc_d   = rx_new;
          byte_cnt_d = cnt_inc;
          if (byte_cnt_q[1:0] == 2'd3) begin
            st_v = 1'b1;
            st   = ((~crc_q) == rx_new) ? ST_OK : ST_CHECKSUM;
          end else if (s1_eod_q) begin
            st_v = 1'b1;
            st   = ST_TRUNC;
          end
        end
        PH_DROP: begin
          if (s1_eod_q) begin
            phase_d    = PH_LEN;
            byte_cnt_d = 32'd0;
            pay_len_d  = 32'd0;
            crc_d      = CrcInit;
            rx_crc_d   = 32'd0;
          end
        end
        default: begin
          // unreachable code: restart framing
          phase_d    = PH_LEN;
          byte_cnt_d = 32'd0;
          pay_len_d  = 32'd0;
          crc_d      = CrcInit;
          rx_crc_d   = 32'd0;
        end
      endcase

      // a status closes the frame; errors without end of data go to drop
      if (st_v) begin
        byte_cnt_d = 32'd0;
        pay_len_d  = 32'd0;
        crc_d      = CrcInit;
        rx_crc_d   = 32'd0;
        phase_d    = ((st == ST_OK) || s1_eod_q) ? PH_LEN : PH_DROP;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN;
      byte_cnt_q  <= 32'd0;
      pay_len_q   <= 32'd0;
      crc_q       <= CrcInit;
      rx_crc_q    <= 32'd0;
      exp_latch_q <= 32'd0;
      chk_latch_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      byte_cnt_q  <= byte_cnt_d;
      pay_len_q   <= pay_len_d;
      crc_q       <= crc_d;
      rx_crc_q    <= rx_crc_d;
      exp_latch_q <= exp_latch_d;
      chk_latch_q <= chk_latch_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= s1_adv && (pay_v || st_v);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_pay_v_q <= pay_v;
      res_byte_q  <= pay_v ? s1_byte_q : 8'd0;
      res_st_v_q  <= st_v;
      res_st_q    <= st_v ? st : ST_OK;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign payload_valid_o = res_pay_v_q;
  assign payload_byte_o  = res_byte_q;
  assign status_valid_o  = res_st_v_q;
  assign status_o        = res_st_q;

  // Checks
  `include "block_frame_crc_verifier_core_assert.svh"

  `BFCV_ASSERT(a_res_nonempty, clk_i, rst_ni, res_valid_q |-> (res_pay_v_q || res_st_v_q), "empty result transaction")
  `BFCV_ASSERT_NEVER(a_drop_silent, clk_i, rst_ni, s1_adv && (phase_q == PH_DROP) && (pay_v || st_v), "result while dropping")
  `BFCV_ASSERT_NEVER(a_pay_phase, clk_i, rst_ni, pay_v && (phase_q != PH_PAY), "payload byte outside payload phase")
  `BFCV_ASSERT(a_eod_restart, clk_i, rst_ni, (s1_adv && s1_eod_q) |=> (phase_q == PH_LEN), "no restart after end of data")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the length-prefixed frame CRC-32C verifier core.
// Depends on bfcv_pkg and block_frame_crc_verifier_core; predicts every result itself.
`timescale 1ns / 100ps

module testbench;
  import bfcv_pkg::*;

  localparam int unsigned HoldCycles  = 300;   // long receiver hold-off
  localparam int unsigned StallLimit  = 3000;  // cycles without any transaction
  localparam int unsigned SettleCycles = 8;    // result latency plus margin
  localparam int unsigned MaxReported = 10;

  typedef struct {
    logic       pay_v;
    logic [7:0] pay_b;
    logic       stat_v;
    status_e    stat;
  } frame_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i     = 8'd0;
  logic        end_of_data_i   = 1'b0;
  logic        check_size_i    = 1'b0;
  logic [31:0] expected_size_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic        status_valid_o;
  logic [1:0]  status_o;

  // Shared controls and bookkeeping
  bit            idle_on   = 1'b0;
  bit            hold_req  = 1'b0;
  int unsigned   items_sent = 0;
  int unsigned   faults     = 0;
  int unsigned   quiet_cycles = 0;
  frame_result_t pending_results[$];

  // Predicted frame parser state
  phase_e      ph      = PH_LEN;
  logic [31:0] cnt     = 32'd0;
  logic [31:0] plen    = 32'd0;
  logic [31:0] crc_acc = 32'hFFFF_FFFF;
  logic [31:0] rx_crc  = 32'd0;
  logic [31:0] exp_l   = 32'd0;
  logic        chk_l   = 1'b0;

  block_frame_crc_verifier_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_data_i  (end_of_data_i),
    .check_size_i   (check_size_i),
    .expected_size_i(expected_size_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_valid_o(payload_valid_o),
    .payload_byte_o (payload_byte_o),
    .status_valid_o (status_valid_o),
    .status_o       (status_o)
  );

  always #6 clk_i = ~clk_i;

  // Reflected CRC-32C, one data bit at a time
  function automatic logic [31:0] castagnoli_next(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ 32'h82F6_3B78;
    end
    return c;
  endfunction

  // Mostly no gap, some short ones, a few long
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (!idle_on || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void frame_restart();
    ph      = PH_LEN;
    cnt     = 32'd0;
    plen    = 32'd0;
    crc_acc = 32'hFFFF_FFFF;
    rx_crc  = 32'd0;
  endfunction

  // Advance the predicted parser by one accepted byte
  function automatic void predict_byte(input logic [7:0] b, input logic eod, input logic cs,
                                       input logic [31:0] es);
    frame_result_t r;
    logic [32:0]   whole;
    r.pay_v  = 1'b0;
    r.pay_b  = 8'd0;
    r.stat_v = 1'b0;
    r.stat   = ST_OK;
    case (ph)
      PH_LEN: begin
        if (cnt == 32'd0) begin
          chk_l   = cs;
          exp_l   = es;
          crc_acc = 32'hFFFF_FFFF;
          rx_crc  = 32'd0;
          plen    = 32'd0;
        end
        plen = plen | ({24'd0, b} << (8 * cnt[1:0]));
        cnt  = cnt + 32'd1;
        if (cnt >= 32'd4) begin
          // frame size taken without wrap
          whole = {1'b0, plen} + FrameOverhead;
          cnt   = 32'd0;
          if (chk_l && whole != {1'b0, exp_l}) begin
            r.stat_v = 1'b1;
            r.stat   = ST_SIZE;
          end else if (eod) begin
            r.stat_v = 1'b1;
            r.stat   = ST_TRUNC;
          end else if (plen == 32'd0) begin
            ph = PH_CRC;
          end else begin
            ph = PH_PAY;
          end
        end else if (eod) begin
          r.stat_v = 1'b1;
          r.stat   = ST_TRUNC;
        end
      end
      PH_PAY: begin
        r.pay_v = 1'b1;
        r.pay_b = b;
        crc_acc = castagnoli_next(crc_acc, b);
        cnt     = cnt + 32'd1;
        if (eod) begin
          r.stat_v = 1'b1;
          r.stat   = ST_TRUNC;
        end else if (cnt >= plen) begin
          cnt = 32'd0;
          ph  = PH_CRC;
        end
      end
      PH_CRC: begin
        rx_crc = rx_crc | ({24'd0, b} << (8 * cnt[1:0]));
        cnt    = cnt + 32'd1;
        if (cnt >= 32'd4) begin
          r.stat_v = 1'b1;
          if (~crc_acc == rx_crc) r.stat = ST_OK;
          else r.stat = ST_CHECKSUM;
        end else if (eod) begin
          r.stat_v = 1'b1;
          r.stat   = ST_TRUNC;
        end
      end
      default: begin
        // dropping until end of data
        if (eod) frame_restart();
      end
    endcase
    if (r.stat_v) begin
      frame_restart();
      if (!(r.stat == ST_OK || eod)) ph = PH_DROP;
    end
    if (r.pay_v || r.stat_v) pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void report_fault(input string msg);
    faults++;
    if (faults <= MaxReported) $display("%s", msg);
  endfunction

  function automatic void check_result();
    frame_result_t e;
    if (pending_results.size() == 0) begin
      report_fault($sformatf("unexpected result: pv=%0b pb=%02h sv=%0b st=%0d",
                             payload_valid_o, payload_byte_o, status_valid_o, status_o));
      return;
    end
    e = pending_results.pop_front();
    if (payload_valid_o !== e.pay_v || payload_byte_o !== e.pay_b ||
        status_valid_o !== e.stat_v || status_o !== e.stat) begin
      report_fault($sformatf("mismatch: exp pv=%0b pb=%02h sv=%0b st=%0d, got pv=%0b pb=%02h sv=%0b st=%0d",
                             e.pay_v, e.pay_b, e.stat_v, e.stat,
                             payload_valid_o, payload_byte_o, status_valid_o, status_o));
    end
  endfunction

  // Prediction on each accepted byte, checking on each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      predict_byte(data_byte_i, end_of_data_i, check_size_i, expected_size_i);
    if (rst_ni && out_valid_o && out_ready_i)
      check_result();
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("[block_frame_crc_verifier_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        gap = idle_gap();
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b, input logic eod, input logic cs,
                           input logic [31:0] es);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_data_i   <= eod;
    check_size_i    <= cs;
    expected_size_i <= es;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender pause until every predicted result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One frame: length, payload (at most 64 bytes sent), CRC if len <= 64; optional eod cut
  task automatic send_frame(input logic [31:0] len, input bit crc_good, input int cut_at,
                            input bit eod_last, input bit chk, input bit size_ok);
    logic [7:0]  fq[$];
    logic [7:0]  pb;
    logic [31:0] crc;
    logic [31:0] exp_sz;
    int          n;
    bit          eod;
    for (int k = 0; k < 4; k++) fq.insert(fq.size(), len[8*k +: 8]);
    crc = 32'hFFFF_FFFF;
    for (int i = 0; i < ((len > 32'd64) ? 64 : int'(len)); i++) begin
      pb  = 8'($urandom);
      fq.insert(fq.size(), pb);
      crc = castagnoli_next(crc, pb);
    end
    crc = ~crc;
    if (!crc_good) crc = crc ^ (32'h1 << $urandom_range(0, 31));
    if (len <= 32'd64)
      for (int k = 0; k < 4; k++) fq.insert(fq.size(), crc[8*k +: 8]);
    exp_sz = len + 32'd8;
    if (!size_ok) begin
      exp_sz = $urandom;
      if ({1'b0, exp_sz} == {1'b0, len} + 33'd8) exp_sz = exp_sz ^ 32'h1;
    end
    n = (cut_at >= 0 && cut_at < fq.size()) ? cut_at + 1 : fq.size();
    for (int i = 0; i < n; i++) begin
      eod = (i == n - 1) && (cut_at >= 0 || eod_last);
      if (i == 0) send_byte(fq[i], eod, chk, exp_sz);
      else send_byte(fq[i], eod, 1'($urandom_range(0, 1)), $urandom);
    end
    // after an error with no end of data the rest is dropped: close it off
    if (((chk && !size_ok) || !crc_good) && !(cut_at >= 0 || eod_last)) begin
      repeat ($urandom_range(0, 4))
        send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), $urandom);
      send_byte(8'($urandom), 1'b1, 1'($urandom_range(0, 1)), $urandom);
    end
  endtask

  task automatic random_frame();
    int unsigned kind;
    logic [31:0] len;
    kind = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 64);
    if (kind < 55)
      send_frame(len, 1'b1, -1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
    else if (kind < 70)
      send_frame(len, 1'b0, -1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
    else if (kind < 80)
      send_frame(len, 1'($urandom_range(0, 1)), -1, 1'($urandom_range(0, 1)), 1'b1, 1'b0);
    else if (kind < 92)
      send_frame(len, 1'b1, int'($urandom_range(0, 6 + len)), 1'b0,
                 1'($urandom_range(0, 1)), 1'b1);
    else
      // huge length, always cut short
      send_frame($urandom | 32'h0001_0000, 1'b1, int'($urandom_range(0, 67)), 1'b0,
                 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Empty payload, checksum error with drop, size check without wrap, size ok then truncation
  task automatic test_boundary_frames();
    logic [31:0] bad;
    send_frame(32'd0, 1'b1, -1, 1'b0, 1'b1, 1'b1);
    bad = ~castagnoli_next(32'hFFFF_FFFF, 8'hFF) ^ 32'h0000_0001;
    send_byte(8'h01, 1'b0, 1'b0, 32'hFFFF_FFFF);
    repeat (3) send_byte(8'h00, 1'b0, 1'b0, 32'h0);
    send_byte(8'hFF, 1'b0, 1'b0, 32'h0);
    for (int k = 0; k < 4; k++) send_byte(bad[8*k +: 8], 1'b0, 1'b0, 32'h0);
    send_byte(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // 8 + 0xFFFFFFF8 wraps to 0 but must not match
    for (int k = 0; k < 4; k++)
      send_byte((k == 0) ? 8'hF8 : 8'hFF, k == 3, k == 0, 32'h0);
    // 8 + 0xFFFFFFF7 matches all ones, so end of data gives truncation
    for (int k = 0; k < 4; k++)
      send_byte((k == 0) ? 8'hF7 : 8'hFF, k == 3, k == 0, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_frames(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_frame();
  endtask

  // Receiver holds off while frames keep coming, so the core must stall its input
  task automatic test_output_hold();
    int unsigned stop_at;
    stop_at  = items_sent + 60;
    hold_req = 1'b1;
    while (items_sent < stop_at) random_frame();
  endtask

  // Unframed bytes with scattered end of data, then resync
  task automatic test_noise_bytes();
    repeat (40)
      send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), $urandom);
    send_byte(8'($urandom), 1'b1, 1'($urandom_range(0, 1)), $urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_boundary_frames();
    drain_results();
    test_random_frames(80);
    drain_results();
    idle_on = 1'b1;
    test_output_hold();
    drain_results();
    test_noise_bytes();
    drain_results();
    test_random_frames(220);
    drain_results();

    if (faults == 0) begin
      $display("[block_frame_crc_verifier_core] OK");
    end else begin
      $display("[block_frame_crc_verifier_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/bfcv_pkg.sv
design/block_frame_crc_verifier_core.sv
tb/testbench.sv
